// ===== rtl/ldb_pkg.sv =====
`timescale 1ns / 1ps

package ldb_pkg;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic load;
        logic out_clear;
        logic clr_init;
        logic clr_step;
        logic rd_pix;
        logic px_write;
        logic rd_byte;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic line_done;
        logic clr_last;
    } t_status;

endpackage

// ===== rtl/ldb_ram.sv =====
`timescale 1ns / 1ps

module ldb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 408,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ldb_ctrl.sv =====
`timescale 1ns / 1ps

module ldb_ctrl
    import ldb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    input  logic [1:0] i_op,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output t_cmd       o_cmd,
    input  t_status    i_status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_LREAD  = 3'd2;
    localparam logic [2:0] S_LWRITE = 3'd3;
    localparam logic [2:0] S_RREAD  = 3'd4;
    localparam logic [2:0] S_RDATA  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_report;
    logic       n_report;

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.out_clear = 1'b1;
                    case (i_op)
                        OP_DRAW: begin
                            n_state = S_LREAD;
                        end
                        OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_report       = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        OP_READ: begin
                            n_state = S_RREAD;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state  = r_report ? S_RESULT : S_IDLE;
                    n_report = 1'b0;
                end
            end
            S_LREAD: begin
                if (i_status.line_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.rd_pix = 1'b1;
                    n_state      = S_LWRITE;
                end
            end
            S_LWRITE: begin
                o_cmd.px_write = 1'b1;
                n_state        = S_LREAD;
            end
            S_RREAD: begin
                o_cmd.rd_byte = 1'b1;
                n_state       = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_RESULT);

endmodule

// ===== rtl/ldb_datapath.sv =====
`timescale 1ns / 1ps

module ldb_datapath
    import ldb_pkg::*;
#(
    parameter int SCREEN_COLS = 48,
    parameter int SCREEN_ROWS = 68
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic       i_pixel_on,
    input  logic [8:0] i_byte_index,
    output logic [7:0] o_read_data
);

    localparam int ROW_BYTES   = (SCREEN_COLS + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_ROWS;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [7:0]    r_x;
    logic [7:0]    r_y;
    logic [7:0]    r_cnt;
    logic [7:0]    r_len_major;
    logic [7:0]    r_len_minor;
    logic [7:0]    r_rem;
    logic          r_x_major;
    logic          r_xneg;
    logic          r_yneg;
    logic          r_on;
    logic [8:0]    r_byte_idx;
    logic [AW-1:0] r_clr_cnt;
    logic [7:0]    r_out;

    logic [7:0]    w_lx;
    logic [7:0]    w_ly;
    logic [8:0]    w_sum;
    logic          w_carry;
    logic          w_visible;
    logic [31:0]   w_pix_full;
    logic [AW-1:0] w_pix_addr;
    logic          w_byte_ok;
    logic [AW-1:0] w_byte_addr;
    logic [7:0]    w_mask;
    logic [7:0]    w_rdata;
    logic [7:0]    w_mod;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    assign w_lx = (i_x_end < i_x_start) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
    assign w_ly = (i_y_end < i_y_start) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);

    assign w_sum   = {1'b0, r_rem} + {1'b0, r_len_minor};
    assign w_carry = (w_sum >= {1'b0, r_len_major});

    assign w_visible  = (32'(r_x) < SCREEN_COLS) && (32'(r_y) < SCREEN_ROWS);
    assign w_pix_full = 32'(r_y) * ROW_BYTES + 32'(r_x[7:3]);
    assign w_pix_addr = w_visible ? w_pix_full[AW-1:0] : '0;

    assign w_byte_ok   = (32'(r_byte_idx) < STORE_BYTES);
    assign w_byte_addr = w_byte_ok ? AW'(r_byte_idx) : '0;

    assign w_mask = 8'd1 << r_x[2:0];
    assign w_mod  = r_on ? (w_rdata | w_mask) : (w_rdata & ~w_mask);

    assign w_we    = i_cmd.clr_step | (i_cmd.px_write & w_visible);
    assign w_waddr = i_cmd.clr_step ? r_clr_cnt : w_pix_addr;
    assign w_wdata = i_cmd.clr_step ? 8'd0 : w_mod;
    assign w_re    = i_cmd.rd_pix | i_cmd.rd_byte;
    assign w_raddr = i_cmd.rd_byte ? w_byte_addr : w_pix_addr;

    ldb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x        <= i_x_start;
            r_y        <= i_y_start;
            r_cnt      <= 8'd0;
            r_rem      <= 8'd0;
            r_xneg     <= (i_x_end < i_x_start);
            r_yneg     <= (i_y_end < i_y_start);
            r_on       <= i_pixel_on;
            r_byte_idx <= i_byte_index;
            r_x_major  <= (w_lx >= w_ly);
            if (w_lx >= w_ly) begin
                r_len_major <= w_lx;
                r_len_minor <= w_ly;
            end else begin
                r_len_major <= w_ly;
                r_len_minor <= w_lx;
            end
        end else if (i_cmd.px_write) begin
            r_cnt <= r_cnt + 8'd1;
            r_rem <= w_carry ? 8'(w_sum - {1'b0, r_len_major}) : w_sum[7:0];
            if (r_x_major || w_carry) begin
                r_x <= r_xneg ? (r_x - 8'd1) : (r_x + 8'd1);
            end
            if (!r_x_major || w_carry) begin
                r_y <= r_yneg ? (r_y - 8'd1) : (r_y + 8'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= o_status.clr_last ? '0 : (r_clr_cnt + AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_clear) begin
            r_out <= 8'd0;
        end else if (i_cmd.out_load) begin
            r_out <= w_byte_ok ? w_rdata : 8'd0;
        end
    end

    assign o_status.line_done = (r_cnt == r_len_major);
    assign o_status.clr_last  = (r_clr_cnt == AW'(STORE_BYTES - 1));
    assign o_read_data        = r_out;

endmodule

// ===== rtl/line_draw_into_bitmap_core.sv =====
`timescale 1ns / 1ps

// One-bit-per-pixel frame store with a line drawing engine.
// The slave channel takes one command per transaction: the opcode travels in
// s_axis_tuser and the line coordinates, pixel value and byte index in
// s_axis_tdata. Every command returns exactly one transaction on the master
// channel carrying one byte: the stored byte for a read, zero otherwise.
// Commands are handled one at a time; s_axis_tready stays low from the
// accepted transaction until its result has been taken.
// A command occupies the block from its accepting cycle to the cycle in which
// its result is taken. A line is drawn pixel by pixel along its major axis,
// each pixel being a read and then a read-modify-write on the single write
// port of the frame store. A byte read reads the store and then loads the
// output register; an unused opcode goes straight to its result. A clear
// zeroes all SCREEN_ROWS * ceil(SCREEN_COLS / 8) store bytes (408 with the
// default geometry), one store byte per cycle. After reset the same clearing
// pass runs, during which no command is accepted. When the receiver stalls,
// the result is held in the output register and no new command is accepted
// until it has been taken.

module line_draw_into_bitmap_core
    import ldb_pkg::*;
#(
    parameter int SCREEN_COLS = 48,
    parameter int SCREEN_ROWS = 68
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24],
    // pixel_on[32], byte_index[41:33], zero padding[47:42]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;

    ldb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_op      (s_axis_tuser),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    ldb_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_x_start    (s_axis_tdata[7:0]),
        .i_y_start    (s_axis_tdata[15:8]),
        .i_x_end      (s_axis_tdata[23:16]),
        .i_y_end      (s_axis_tdata[31:24]),
        .i_pixel_on   (s_axis_tdata[32]),
        .i_byte_index (s_axis_tdata[41:33]),
        .o_read_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/ldb_checker.sv =====
`timescale 1ns / 1ps

module ldb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled result must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // Only one command is in flight: an accepted transaction closes the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while another was in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while a result is pending");

    // Reset starts the clearing pass, so nothing is accepted right after it.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block not busy clearing after reset");

endmodule

bind line_draw_into_bitmap_core ldb_checker u_ldb_checker (.*);
